// ===== hdl/dap_pkg.sv =====
package dap_pkg;

  // Width of the signed result and of the magnitude kept while parsing
  localparam int ACC_WIDTH = 64;
  localparam int MAG_W = ACC_WIDTH - 1;

  // Fraction digits: register width and the largest scale supported
  localparam int MINOR_W = 2;
  localparam int MAX_MINOR_DIGITS = 3;
  localparam logic [MINOR_W-1:0] MINOR_RESET = 2'd2;

  // Scale factor 10^n for n up to 3 fits ten bits
  localparam int SCALE_W = 10;

  // Token queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Characters of interest
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    TOK_SKIP,
    TOK_PLUS,
    TOK_MINUS,
    TOK_DIGIT,
    TOK_POINT,
    TOK_OTHER
  } tok_kind_e;

  typedef enum logic [1:0] {
    PH_START,
    PH_WHOLE,
    PH_FRAC
  } phase_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
    logic       last;
  } token_t;

  // Ten to the power n for the zero padding of missing fraction digits
  function automatic logic [SCALE_W-1:0] pow10_scale(input logic [MINOR_W-1:0] n);
    logic [SCALE_W-1:0] s;
    case (n)
      2'd0: s = 10'd1;
      2'd1: s = 10'd10;
      2'd2: s = 10'd100;
      default: s = 10'd1000;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/decimal_amount_parser_core.sv =====
// Decimal amount parser: one ASCII byte per cycle in while full is low, one
// signed amount in minor units out per string.
// Input channel: a byte and its last flag are transferred on a rising edge
// with push high and full low. Skipped bytes (whitespace, '$', ',') that do
// not close a string are dropped straight away; the rest enter a four-entry
// token queue.
// Result channel: while empty is low, valid_res_o and amount_o show the
// oldest result; it is transferred on an edge with pop high and empty low.
// Each string gives exactly one result, on its last byte.
// Throughput is one byte per cycle while results are popped: the accumulator
// takes one digit each cycle, and scaling and sign run in two stages behind
// it, then the output register; empty goes low once the result reaches it.
// When pop stays low the result stages fill, then the token queue, and full
// rises; nothing is lost.
// Configuration: cfg_minor_digits_i is written on an edge with cfg_valid_i
// high; cfg_ready_o is always high. Write it only while the block is idle.
// Reset clears the parser, empties all stages and sets minor digits to 2.
module decimal_amount_parser_core
  import dap_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [MINOR_W-1:0]   cfg_minor_digits_i,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           character_i,
  input  logic                 last_i,
  output logic                 empty,
  input  logic                 pop,
  output logic                 valid_res_o,
  output logic [ACC_WIDTH-1:0] amount_o
);

  logic [MINOR_W-1:0] minor_digits_q;
  logic               q_wr, q_rd, q_valid, q_full;
  token_t             wr_tok, rd_tok;

  assign cfg_ready_o = 1'b1;
  assign full = q_full;

  // Hold the scale register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minor_digits_q <= MINOR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      minor_digits_q <= cfg_minor_digits_i;
    end
  end

  dap_front u_front (
    .push_i      (push),
    .q_full_i    (q_full),
    .character_i (character_i),
    .last_i      (last_i),
    .wr_o        (q_wr),
    .tok_o       (wr_tok)
  );

  dap_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_tok_i (wr_tok),
    .rd_i     (q_rd),
    .valid_o  (q_valid),
    .rd_tok_o (rd_tok),
    .full_o   (q_full)
  );

  dap_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .minor_digits_i (minor_digits_q),
    .tok_valid_i    (q_valid),
    .tok_i          (rd_tok),
    .tok_rd_o       (q_rd),
    .empty_o        (empty),
    .pop_i          (pop),
    .valid_res_o    (valid_res_o),
    .amount_o       (amount_o)
  );

endmodule

// ===== hdl/dap_front.sv =====
module dap_front
  import dap_pkg::*;
(
  input  logic       push_i,
  input  logic       q_full_i,
  input  logic [7:0] character_i,
  input  logic       last_i,
  output logic       wr_o,
  output token_t     tok_o
);

  tok_kind_e kind;

  // Classify the byte
  always_comb begin
    if (character_i == CH_SPACE || (character_i >= CH_TAB && character_i <= CH_CR) ||
        character_i == CH_DOLLAR || character_i == CH_COMMA) begin
      kind = TOK_SKIP;
    end else if (character_i == CH_PLUS) begin
      kind = TOK_PLUS;
    end else if (character_i == CH_MINUS) begin
      kind = TOK_MINUS;
    end else if (character_i >= CH_ZERO && character_i <= CH_NINE) begin
      kind = TOK_DIGIT;
    end else if (character_i == CH_POINT) begin
      kind = TOK_POINT;
    end else begin
      kind = TOK_OTHER;
    end
  end

  assign tok_o.kind = kind;
  assign tok_o.digit = character_i[3:0];
  assign tok_o.last = last_i;

  // Drop skipped bytes unless they close the string
  assign wr_o = push_i && !q_full_i && !(kind == TOK_SKIP && !last_i);

endmodule

// ===== hdl/dap_queue.sv =====
module dap_queue
  import dap_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  token_t wr_tok_i,
  input  logic   rd_i,
  output logic   valid_o,
  output token_t rd_tok_o,
  output logic   full_o
);

  token_t             entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_q, wptr_d;
  logic [QPTR_W-1:0]  rptr_q, rptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign rd_tok_o = entries_q[rptr_q];

  // Advance pointers and fill count
  always_comb begin
    wptr_d = wr_i ? wptr_q + QPTR_W'(1) : wptr_q;
    rptr_d = rd_i ? rptr_q + QPTR_W'(1) : rptr_q;
    cnt_d = cnt_q;
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q <= cnt_d;
    end
  end

  // Store a token
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entries_q[wptr_q] <= wr_tok_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("token queue count beyond depth");
  a_no_wr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o || rd_i)
    else $error("token queue written while full");
  a_no_rd_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> valid_o)
    else $error("token queue read while empty");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i && !rd_i |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
    else $error("token queue count did not rise");
`endif

endmodule

// ===== hdl/dap_back.sv =====
module dap_back
  import dap_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [MINOR_W-1:0]   minor_digits_i,
  input  logic                 tok_valid_i,
  input  token_t               tok_i,
  output logic                 tok_rd_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic                 valid_res_o,
  output logic [ACC_WIDTH-1:0] amount_o
);

  // String state
  phase_e             phase_q, phase_d;
  logic               neg_q, neg_d;
  logic               digit_q, digit_d;
  logic [MINOR_W-1:0] frac_q, frac_d;
  logic               bad_q, bad_d;
  logic               ovf_q, ovf_d;
  logic [MAG_W-1:0]   acc_q, acc_d;

  phase_e             eff_phase;
  logic [MAG_W+3:0]   acc_ext;
  logic [MAG_W+3:0]   push_sum;

  // Scale stage
  logic               b_v_q;
  logic [MAG_W-1:0]   b_mag_q;
  logic [MINOR_W-1:0] b_pad_q;
  logic               b_neg_q;
  logic               b_ok_q;
  logic [MAG_W+SCALE_W-1:0] prod;

  // Sign stage
  logic               c_v_q;
  logic [MAG_W-1:0]   c_mag_q;
  logic               c_neg_q;
  logic               c_ok_q;
  logic [ACC_WIDTH-1:0] c_amount;

  // Output register
  logic               out_v_q;

  logic out_ready, c_ready, b_ready, finish, scale_ok;

  assign out_ready = !out_v_q || pop_i;
  assign c_ready = !c_v_q || out_ready;
  assign b_ready = !b_v_q || c_ready;
  assign tok_rd_o = tok_valid_i && (!tok_i.last || b_ready);
  assign finish = tok_rd_o && tok_i.last;
  assign empty_o = !out_v_q;
  assign scale_ok = (32'(minor_digits_i) <= MAX_MINOR_DIGITS);

  // Multiply-accumulate by ten for one digit
  assign acc_ext = {4'b0, acc_q};
  assign push_sum = (acc_ext << 3) + (acc_ext << 1) + {{MAG_W{1'b0}}, tok_i.digit};

  // Step the string state for one token
  always_comb begin
    phase_d = phase_q;
    neg_d = neg_q;
    digit_d = digit_q;
    frac_d = frac_q;
    bad_d = bad_q;
    ovf_d = ovf_q;
    acc_d = acc_q;
    eff_phase = (phase_q == PH_START) ? PH_WHOLE : phase_q;
    case (tok_i.kind)
      TOK_SKIP: begin
      end
      TOK_PLUS, TOK_MINUS: begin
        phase_d = PH_WHOLE;
        if (phase_q == PH_START) begin
          neg_d = (tok_i.kind == TOK_MINUS);
        end else begin
          bad_d = 1'b1;
        end
      end
      TOK_DIGIT: begin
        phase_d = eff_phase;
        if (eff_phase == PH_FRAC && frac_q >= minor_digits_i) begin
          bad_d = 1'b1;
        end else begin
          if (eff_phase == PH_FRAC) begin
            frac_d = frac_q + MINOR_W'(1);
          end
          digit_d = 1'b1;
          if (!ovf_q) begin
            if (push_sum[MAG_W+3:MAG_W] != '0) begin
              ovf_d = 1'b1;
            end else begin
              acc_d = push_sum[MAG_W-1:0];
            end
          end
        end
      end
      TOK_POINT: begin
        if (eff_phase == PH_FRAC) begin
          bad_d = 1'b1;
        end else begin
          phase_d = PH_FRAC;
        end
      end
      default: begin
        phase_d = eff_phase;
        bad_d = 1'b1;
      end
    endcase
  end

  // Hold string state; clear it when the last byte is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q <= 1'b0;
      digit_q <= 1'b0;
      frac_q <= '0;
      bad_q <= 1'b0;
      ovf_q <= 1'b0;
      acc_q <= '0;
    end else if (finish) begin
      phase_q <= PH_START;
      neg_q <= 1'b0;
      digit_q <= 1'b0;
      frac_q <= '0;
      bad_q <= 1'b0;
      ovf_q <= 1'b0;
      acc_q <= '0;
    end else if (tok_rd_o) begin
      phase_q <= phase_d;
      neg_q <= neg_d;
      digit_q <= digit_d;
      frac_q <= frac_d;
      bad_q <= bad_d;
      ovf_q <= ovf_d;
      acc_q <= acc_d;
    end
  end

  // Capture the finished string for scaling
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_ready) begin
      b_v_q <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      b_mag_q <= acc_d;
      b_pad_q <= minor_digits_i - frac_d;
      b_neg_q <= neg_d;
      b_ok_q <= !bad_d && digit_d && !ovf_d && scale_ok;
    end
  end

  // Pad missing fraction digits with zeros
  assign prod = (MAG_W+SCALE_W)'(b_mag_q) * (MAG_W+SCALE_W)'(pow10_scale(b_pad_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (c_ready) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && b_v_q) begin
      c_mag_q <= prod[MAG_W-1:0];
      c_neg_q <= b_neg_q;
      c_ok_q <= b_ok_q && (prod[MAG_W+SCALE_W-1:MAG_W] == '0);
    end
  end

  // Apply sign, force zero when invalid
  always_comb begin
    if (!c_ok_q) begin
      c_amount = '0;
    end else if (c_neg_q) begin
      c_amount = '0 - {1'b0, c_mag_q};
    end else begin
      c_amount = {1'b0, c_mag_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && c_v_q) begin
      valid_res_o <= c_ok_q;
      amount_o <= c_amount;
    end
  end

`ifndef SYNTH
  a_no_take_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> b_ready)
    else $error("last token taken while scale stage blocked");
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> phase_q == PH_START && acc_q == '0 && !bad_q)
    else $error("string state not cleared after last token");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !pop_i |=> out_v_q && $stable(amount_o) && $stable(valid_res_o))
    else $error("waiting result changed");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !valid_res_o |-> amount_o == '0)
    else $error("invalid result carries a non-zero amount");
`endif

endmodule
